// ----- hdl/alb_pkg.sv -----
`timescale 1ns / 1ps
package alb_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the channels
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 5;
  localparam int ENTRY_W  = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       payload;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    rec_t             wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

// ----- hdl/alb_if.sv -----
`timescale 1ns / 1ps
interface alb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic signed [31:0] key;
  logic [31:0] payload;
  logic [5:0]  position;

  modport source (output valid, command, key, payload, position, input ready);
  modport sink   (input valid, command, key, payload, position, output ready);
endinterface

interface alb_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  found_index;
  logic signed [31:0] key_out;
  logic [31:0] payload_out;
  logic [5:0]  entry_count;

  modport source (output valid, status, found_index, key_out, payload_out, entry_count,
                  input ready);
  modport sink   (input valid, status, found_index, key_out, payload_out, entry_count,
                  output ready);
endinterface

// ----- hdl/array_list_binary_search_top.sv -----
`timescale 1ns / 1ps
// Insert, bad remove and unused command complete directly from idle; remove at 1-based
// position p reads the record at p, then moves each later record down one slot, one record moved
// per cycle through the record RAM; search reads and compares one probe at a time until a hit
// or until the search range is empty.
// One command in flight: a new command is taken only in idle, once the result register is free or being read.
// Reset (rst_n, synchronous, active low) empties the list; RAM contents are not cleared.
module array_list_binary_search_top (
  input logic       clk,
  input logic       rst_n,
  alb_in_if.sink    in_ch,
  alb_out_if.source out_ch
);
  import alb_pkg::*;

  ram_req_t ram_req;
  rec_t     ram_rdata;

  alb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  alb_ram #(
    .WIDTH (REC_W),
    .DEPTH (CAPACITY)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- hdl/alb_ram.sv -----
`timescale 1ns / 1ps
module alb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/alb_ctrl.sv -----
`timescale 1ns / 1ps
module alb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  alb_in_if.sink            in_ch,
  alb_out_if.source         out_ch,
  output alb_pkg::ram_req_t ram_req,
  input  alb_pkg::rec_t     ram_rdata
);
  import alb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_REM_RD    = 5'b00010,
    S_REM_SHIFT = 5'b00100,
    S_SRCH_RD   = 5'b01000,
    S_SRCH_CMP  = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        lo_r, lo_nxt;
  logic [CNT_W-1:0]        hi_r, hi_nxt;
  logic [IDX_W-1:0]        mid_r, mid_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic                    first_r, first_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [FOUND_W-1:0]      out_found_r, out_found_nxt;
  logic signed [KEY_W-1:0] out_key_r, out_key_nxt;
  logic [DATA_W-1:0]       out_payload_r, out_payload_nxt;
  logic [ENTRY_W-1:0]      out_count_r, out_count_nxt;

  logic                    in_ready;
  logic                    accept;
  logic                    done;
  status_t                 res_status;
  logic [FOUND_W-1:0]      res_found;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid_full;
  logic [CNT_W-1:0]        idx_m2;
  logic [CNT_W-1:0]        pos_m1;
  logic                    pos_bad;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_full = mid_sum[CNT_W:1];
  assign idx_m2   = idx_r - CNT_W'(2);
  assign pos_m1   = CNT_W'(in_ch.position) - CNT_W'(1);
  assign pos_bad  = (in_ch.position == '0) ||
                    (CMP_W'(in_ch.position) > CMP_W'(count_r));

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    key_nxt         = key_r;
    first_nxt       = first_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_found_nxt   = out_found_r;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_count_nxt   = out_count_r;
    ram_req         = '0;
    done            = 1'b0;
    res_status      = ST_OK;
    res_found       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_key_nxt     = '0;
          out_payload_nxt = '0;
          case (cmd_t'(in_ch.command))
            CMD_INSERT: begin
              done = 1'b1;
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                ram_req.we            = 1'b1;
                ram_req.waddr         = count_r[IDX_W-1:0];
                ram_req.wdata.key     = in_ch.key;
                ram_req.wdata.payload = in_ch.payload;
                count_nxt             = count_r + CNT_W'(1);
              end
            end
            CMD_REMOVE: begin
              if (pos_bad) begin
                done       = 1'b1;
                res_status = ST_BADPOS;
              end else begin
                idx_nxt   = pos_m1;
                first_nxt = 1'b1;
                state_nxt = S_REM_RD;
              end
            end
            CMD_SEARCH: begin
              key_nxt   = in_ch.key;
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = S_SRCH_RD;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      S_REM_RD: begin
        ram_req.raddr = idx_r[IDX_W-1:0];
        idx_nxt       = idx_r + CNT_W'(1);
        state_nxt     = S_REM_SHIFT;
      end

      // rdata holds the entry at idx_r-1; move it down one slot, or on the first pass return it as the removed record
      S_REM_SHIFT: begin
        first_nxt = 1'b0;
        if (first_r) begin
          out_key_nxt     = ram_rdata.key;
          out_payload_nxt = ram_rdata.payload;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_m2[IDX_W-1:0];
          ram_req.wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          ram_req.raddr = idx_r[IDX_W-1:0];
          idx_nxt       = idx_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          ram_req.raddr = mid_full[IDX_W-1:0];
          mid_nxt       = mid_full[IDX_W-1:0];
          state_nxt     = S_SRCH_CMP;
        end else begin
          done       = 1'b1;
          res_status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end

      S_SRCH_CMP: begin
        if (ram_rdata.key == key_r) begin
          done      = 1'b1;
          res_found = FOUND_W'(mid_r);
          state_nxt = S_IDLE;
        end else if (key_r < ram_rdata.key) begin
          hi_nxt    = CNT_W'(mid_r);
          state_nxt = S_SRCH_RD;
        end else begin
          lo_nxt    = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = S_SRCH_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_found_nxt  = res_found;
      out_count_nxt  = ENTRY_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    key_r         <= key_nxt;
    out_status_r  <= out_status_nxt;
    out_found_r   <= out_found_nxt;
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_index = out_found_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.payload_out = out_payload_r;
  assign out_ch.entry_count = out_count_r;

endmodule

// ----- sim/tb_array_list_binary_search_top.sv -----
`timescale 1ns / 1ps
module tb_array_list_binary_search_top;
  import alb_pkg::*;

  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 50;
  localparam int RANDOM_ITEMS  = 1350;
  localparam int MAX_PRINTED   = 100;

  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef struct {
    status_t                 status;
    logic [FOUND_W-1:0]      found_index;
    logic signed [KEY_W-1:0] key_out;
    logic [DATA_W-1:0]       payload_out;
    logic [ENTRY_W-1:0]      entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  alb_in_if  in_ch ();
  alb_out_if out_ch ();

  array_list_binary_search_top dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the list, updated on every accepted input transfer
  logic signed [KEY_W-1:0] list_keys [CAPACITY];
  logic [DATA_W-1:0]       list_payloads [CAPACITY];
  int                      list_count = 0;
  list_result_t            pending_results [$];

  int errors       = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int status_tally [4] = '{default: 0};
  int cmd_tally [4]    = '{default: 0};

  bit src_idle     = 1'b1;
  bit sink_idle    = 1'b1;
  bit hold_request = 1'b0;

  function automatic list_result_t apply_command(cmd_t cmd, logic signed [KEY_W-1:0] key,
                                                 logic [DATA_W-1:0] payload,
                                                 logic [POS_W-1:0] position);
    list_result_t r;
    int lo;
    int hi;
    int mid;
    r = '{ST_OK, '0, '0, '0, '0};
    case (cmd)
      CMD_INSERT: begin
        if (list_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_keys[list_count]     = key;
          list_payloads[list_count] = payload;
          list_count++;
        end
      end
      CMD_REMOVE: begin
        if (list_count == 0 || position == 0 || position > list_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.key_out     = list_keys[position - 1];
          r.payload_out = list_payloads[position - 1];
          for (int i = position; i < list_count; i++) begin
            list_keys[i - 1]     = list_keys[i];
            list_payloads[i - 1] = list_payloads[i];
          end
          list_count--;
        end
      end
      CMD_SEARCH: begin
        lo = 0;
        hi = list_count;
        r.status = ST_NOTFOUND;
        while (lo < hi && r.status == ST_NOTFOUND) begin
          mid = (lo + hi) / 2;
          if (list_keys[mid] == key) begin
            r.status      = ST_OK;
            r.found_index = mid[FOUND_W-1:0];
          end else if (key < list_keys[mid]) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
      end
      default: ;
    endcase
    r.entry_count = list_count[ENTRY_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("%0t: mismatch: %s", $time, msg);
  endtask

  // result checking and prediction share one process so queue order is fixed
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                    results_seen));
        end else begin
          want = pending_results.pop_front();
          status_tally[want.status]++;
          if (out_ch.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_seen, out_ch.status, want.status));
          if (out_ch.found_index !== want.found_index)
            report_mismatch($sformatf("result %0d found_index %0d, expected %0d",
                                      results_seen, out_ch.found_index, want.found_index));
          if (out_ch.key_out !== want.key_out)
            report_mismatch($sformatf("result %0d key_out %0h, expected %0h",
                                      results_seen, out_ch.key_out, want.key_out));
          if (out_ch.payload_out !== want.payload_out)
            report_mismatch($sformatf("result %0d payload_out %0h, expected %0h",
                                      results_seen, out_ch.payload_out, want.payload_out));
          if (out_ch.entry_count !== want.entry_count)
            report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                      results_seen, out_ch.entry_count, want.entry_count));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd_tally[in_ch.command]++;
        pending_results.push_back(apply_command(cmd_t'(in_ch.command), in_ch.key,
                                                in_ch.payload, in_ch.position));
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles = stall_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(sink_idle && $urandom_range(0, 99) < 23);
      end
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("No transfer for %0d cycles, %0d results outstanding",
             stall_cycles, pending_results.size());
    $display("FAIL");
    $finish;
  end

  // called and returns at a falling edge; valid stays high into the next call
  task automatic send_item(cmd_t cmd, logic signed [KEY_W-1:0] key,
                           logic [DATA_W-1:0] payload, logic [POS_W-1:0] position);
    while (src_idle && $urandom_range(0, 99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.key      <= key;
    in_ch.payload  <= payload;
    in_ch.position <= position;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_list();
    send_item(CMD_REMOVE, '0, '0, 6'd0);
    send_item(CMD_REMOVE, '0, '0, 6'd1);
    send_item(CMD_SEARCH, '0, '0, 6'd0);
    send_item(CMD_NONE, KEY_MAX, '1, 6'd63);
  endtask

  task automatic test_boundary_records();
    send_item(CMD_INSERT, KEY_MIN, '0, 6'd0);
    send_item(CMD_INSERT, -32'sd1, '1, 6'd0);
    send_item(CMD_INSERT, '0, 32'ha5a5_a5a5, 6'd0);
    send_item(CMD_INSERT, KEY_MAX, 32'h5a5a_5a5a, 6'd0);
  endtask

  task automatic test_search_cases();
    send_item(CMD_SEARCH, KEY_MIN, '0, 6'd0);
    send_item(CMD_SEARCH, KEY_MAX, '0, 6'd0);
    send_item(CMD_SEARCH, 32'sd5, '0, 6'd0);
    send_item(CMD_SEARCH, '0, '0, 6'd0);
    send_item(CMD_NONE, '0, '0, 6'd0);
  endtask

  task automatic test_remove_cases();
    send_item(CMD_REMOVE, '0, '0, 6'd0);
    send_item(CMD_REMOVE, '0, '0, 6'd5);
    send_item(CMD_REMOVE, '0, '0, 6'd63);
    send_item(CMD_REMOVE, '0, '0, 6'd4);
    send_item(CMD_REMOVE, '0, '0, 6'd1);
    send_item(CMD_REMOVE, '0, '0, 6'd2);
  endtask

  // equal keys, then a key out of order that the halving search skips past
  task automatic test_duplicate_and_unsorted_keys();
    send_item(CMD_INSERT, 32'sd7, 32'h0000_0007, 6'd0);
    send_item(CMD_INSERT, 32'sd7, 32'h0000_0107, 6'd0);
    send_item(CMD_INSERT, 32'sd3, 32'h0000_0003, 6'd0);
    send_item(CMD_SEARCH, 32'sd3, '0, 6'd0);
    send_item(CMD_SEARCH, 32'sd7, '0, 6'd0);
  endtask

  task automatic test_fill_to_capacity();
    logic signed [KEY_W-1:0] k;
    while (list_count > 0) send_item(CMD_REMOVE, '0, '0, 6'd1);
    k = {1'b1, 31'($urandom_range(0, 1000))};
    repeat (CAPACITY) begin
      send_item(CMD_INSERT, k, $urandom(), 6'd0);
      k = k + $urandom_range(1, 1 << 25);
    end
    repeat (2) send_item(CMD_INSERT, $urandom(), $urandom(), 6'd0);
    repeat (6) send_item(CMD_SEARCH, list_keys[$urandom_range(0, CAPACITY - 1)], '0, 6'd0);
    send_item(CMD_SEARCH, list_keys[$urandom_range(0, CAPACITY - 1)] + 1, '0, 6'd0);
    send_item(CMD_SEARCH, KEY_MAX, '0, 6'd0);
    send_item(CMD_REMOVE, '0, '0, 6'd33);
    // head removal moves every other record: longest latency
    send_item(CMD_REMOVE, '0, '0, 6'd1);
    send_item(CMD_INSERT, KEY_MAX, '1, 6'd0);
    send_item(CMD_REMOVE, '0, '0, 6'd32);
  endtask

  task automatic test_output_backpressure();
    drain_results();
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (12) begin
      send_item(cmd_t'($urandom_range(0, 2)), list_keys[$urandom_range(0, list_count - 1)],
                $urandom(), 6'($urandom_range(1, list_count)));
    end
    drain_results();
  endtask

  task automatic test_random_sessions();
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] k;
    logic [POS_W-1:0]        pos;
    bit                      growing;
    int                      pick;
    longint                  next_key;
    growing = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end
      if (n == 650) begin
        src_idle  = 1'b1;
        sink_idle = 1'b1;
      end
      if (list_count == CAPACITY) growing = 1'b0;
      else if (list_count == 0) growing = 1'b1;
      else if ($urandom_range(0, 29) == 0) growing = !growing;
      pick = $urandom_range(0, 99);
      k    = $urandom();
      pos  = POS_W'($urandom_range(0, 63));
      if (pick < 8) begin
        cmd = cmd_t'($urandom_range(0, 3));
      end else if (pick < (growing ? 60 : 30)) begin
        cmd = CMD_INSERT;
        if (list_count == 0) begin
          // leave headroom for an ascending run
          k[KEY_W-2] = 1'b0;
        end else begin
          next_key = longint'(list_keys[list_count - 1]) +
                     (($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                  : $urandom_range(1, 1 << 24));
          if (next_key <= longint'(KEY_MAX)) k = next_key[KEY_W-1:0];
        end
      end else if (pick < 75) begin
        cmd = CMD_REMOVE;
        if (list_count > 0 && $urandom_range(0, 9) != 0)
          pos = POS_W'($urandom_range(1, list_count));
      end else begin
        cmd = CMD_SEARCH;
        if (list_count > 0 && pick < 95) begin
          k = list_keys[$urandom_range(0, list_count - 1)];
          if (pick >= 90) k = $urandom_range(0, 1) ? k + 32'sd1 : k - 32'sd1;
        end
      end
      send_item(cmd, k, $urandom(), pos);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_NONE;
    in_ch.key      = '0;
    in_ch.payload  = '0;
    in_ch.position = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_list();
    test_boundary_records();
    test_search_cases();
    test_remove_cases();
    test_duplicate_and_unsorted_keys();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_sessions();

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Commands sent: %0d insert, %0d remove, %0d search, %0d unused; %0d results checked",
             cmd_tally[CMD_INSERT], cmd_tally[CMD_REMOVE], cmd_tally[CMD_SEARCH],
             cmd_tally[CMD_NONE], results_seen);
    $display("Outcomes: %0d ok, %0d list full, %0d bad position, %0d key absent; %0d mismatches",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_BADPOS],
             status_tally[ST_NOTFOUND], errors);
    if (errors == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- array_list_binary_search_top.f -----
hdl/alb_pkg.sv
hdl/alb_if.sv
hdl/alb_ram.sv
hdl/alb_ctrl.sv
hdl/array_list_binary_search_top.sv
sim/tb_array_list_binary_search_top.sv
